[sv/atlas_shelf_allocator_defines.svh]
// assertion helpers for the shelf allocator
`ifndef ATLAS_SHELF_ALLOCATOR_DEFINES_SVH
`define ATLAS_SHELF_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define ASA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("shelf allocator check failed");

// next-cycle implication
`define ASA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("shelf allocator check failed");

`endif

[sv/asa_pkg.sv]
package asa_pkg;

  // internal arithmetic width, holds sums of two 13-bit quantities
  localparam int AW = 15;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO    = 2'd1;
  localparam logic [1:0] ST_BIG     = 2'd2;
  localparam logic [1:0] ST_NOSPACE = 2'd3;

  localparam logic [1:0] REQ_GLYPH  = 2'd0;
  localparam logic [1:0] REQ_ICON   = 2'd1;
  localparam logic [1:0] REQ_RESET  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [2:0] ICON_CH = 3'd4;

  // request broadcast to every cell
  typedef struct packed {
    logic          icon;
    logic [AW-1:0] desired;
    logic [AW-1:0] w;
    logic [AW-1:0] size;
  } req_t;

  // new row write
  typedef struct packed {
    logic          we;
    logic          is_icon;
    logic          full;
    logic [AW-1:0] height;
    logic [AW-1:0] base_y;
    logic [AW-1:0] fill;
    logic [1:0]    ch;
  } wr_t;

  // search token walking the chain
  typedef struct packed {
    logic          active;
    logic          hit;
    logic [AW-1:0] x;
    logic [AW-1:0] y;
    logic [2:0]    ch;
  } tok_t;

endpackage

[sv/atlas_shelf_allocator.sv]
// shelf-row rectangle allocator for a square texture atlas. a request is
// taken when start is high and busy is low; exactly one result beat follows,
// shown for one cycle with valid_o high, and the receiver cannot stall it.
// reset and out-of-range requests answer one cycle after acceptance. a
// placement walks a search token down a chain of MAX_ROWS row cells, one cell
// per cycle; a row hit answers once the token leaves the last cell, and a
// miss first goes through an allocation state that tries to open a new row.
// the next request may be taken in the cycle that shows the result. a config
// write is taken only while idle with start low, and clears all usage.
module atlas_shelf_allocator #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_SIZE = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [12:0] width_i,
  input  logic [12:0] height_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [11:0] pos_x_o,
  output logic [11:0] pos_y_o,
  output logic [2:0]  channel_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i
);
  import asa_pkg::*;
  `include "atlas_shelf_allocator_defines.svh"

  localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RW = $clog2(MAX_ROWS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_ALLOC = 3'b100
  } state_e;

  state_e state_q, state_d;

  // config and usage state
  logic [12:0]   tex_q;
  logic [AW-1:0] eff_size;
  logic [AW-1:0] top_q [4];
  logic [AW-1:0] floor_q;
  logic [RW-1:0] used_q;

  // latched request
  logic          icon_q;
  logic [AW-1:0] w_q, desired_q;
  logic          launch_q;

  // result beat registers
  logic          valid_q;
  logic [1:0]    status_q;
  logic [11:0]   x_q, y_q;
  logic [2:0]    ch_q;

  // chain wiring
  tok_t          tok [MAX_ROWS+1];
  req_t          req;
  wr_t           wr;
  logic          clear;

  // effective atlas edge, clamped to 4..MAX_SIZE
  always_comb begin
    eff_size = {2'b00, tex_q};
    if (eff_size < AW'(4)) eff_size = AW'(4);
    if (eff_size > AW'(MAX_SIZE)) eff_size = AW'(MAX_SIZE);
  end

  logic accept, cfg_wr;
  logic in_zero, in_big;
  assign accept  = start && (state_q == S_IDLE);
  assign cfg_wr  = cfg_valid_i && cfg_ready_o;
  assign in_zero = (width_i == '0) || (height_i == '0);
  assign in_big  = ({2'b00, width_i} > eff_size) || ({2'b00, height_i} > eff_size);
  assign clear   = cfg_wr || (accept && (req_type_i == REQ_RESET));

  assign req.icon    = icon_q;
  assign req.desired = desired_q;
  assign req.w       = w_q;
  assign req.size    = eff_size;

  // token enters the first cell in the cycle after acceptance
  always_comb begin
    tok[0]        = '0;
    tok[0].active = launch_q;
  end

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    asa_cell #(.IW(IW)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (IW'(g)),
      .clear_i  (clear),
      .req_i    (req),
      .wr_i     (wr),
      .wr_idx_i (used_q[IW-1:0]),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1])
    );
  end

  tok_t tail;
  assign tail = tok[MAX_ROWS];

  // new row: lowest channel for glyphs (ties to the lower one), ending at the icon floor for icons
  logic [1:0]    min_c;
  logic [AW-1:0] glyph_top, icon_y;
  logic          table_full, no_room;
  always_comb begin
    min_c = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (top_q[k] < top_q[min_c]) min_c = 2'(k);
    end
    glyph_top  = top_q[min_c] + desired_q;
    icon_y     = floor_q - desired_q;
    table_full = (used_q >= RW'(MAX_ROWS));
    if (icon_q) begin
      no_room = (desired_q > floor_q);
      for (int k = 0; k < 4; k++) begin
        if (icon_y < top_q[k]) no_room = 1'b1;
      end
    end else begin
      no_room = (glyph_top > floor_q);
    end
  end

  logic alloc_ok;
  assign alloc_ok = (state_q == S_ALLOC) && !table_full && !no_room;

  always_comb begin
    wr.we      = alloc_ok;
    wr.is_icon = icon_q;
    wr.full    = (w_q == eff_size);
    wr.height  = desired_q;
    wr.base_y  = icon_q ? icon_y : top_q[min_c];
    wr.fill    = w_q;
    wr.ch      = icon_q ? 2'd0 : min_c;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && !in_zero && !in_big &&
            (req_type_i == REQ_GLYPH || req_type_i == REQ_ICON)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.active) state_d = tail.hit ? S_IDLE : S_ALLOC;
      end
      S_ALLOC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      tex_q    <= 13'd1024;
      floor_q  <= (MAX_SIZE < 1024) ? AW'(MAX_SIZE) : AW'(1024);
      used_q   <= '0;
      for (int k = 0; k < 4; k++) top_q[k] <= '0;
      launch_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= (state_q == S_IDLE) && (state_d == S_SCAN);
      valid_q  <= 1'b0;
      if (cfg_wr) begin
        tex_q <= cfg_data_i;
        // clamp the new edge for the icon floor
        if ({2'b00, cfg_data_i} < AW'(4)) floor_q <= AW'(4);
        else if ({2'b00, cfg_data_i} > AW'(MAX_SIZE)) floor_q <= AW'(MAX_SIZE);
        else floor_q <= {2'b00, cfg_data_i};
        used_q <= '0;
        for (int k = 0; k < 4; k++) top_q[k] <= '0;
      end
      if (accept) begin
        // anything that does not walk the chain answers right away
        if (state_d == S_IDLE) valid_q <= 1'b1;
        if (req_type_i == REQ_RESET) begin
          floor_q <= eff_size;
          used_q  <= '0;
          for (int k = 0; k < 4; k++) top_q[k] <= '0;
        end
      end
      if (state_q == S_SCAN && tail.active && tail.hit) valid_q <= 1'b1;
      if (state_q == S_ALLOC) begin
        valid_q <= 1'b1;
        if (alloc_ok) begin
          used_q <= used_q + RW'(1);
          if (icon_q) floor_q <= icon_y;
          else top_q[min_c] <= glyph_top;
        end
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      icon_q    <= (req_type_i == REQ_ICON);
      w_q       <= {2'b00, width_i};
      desired_q <= ({2'b00, height_i} + AW'(3)) & ~AW'(3);
      x_q       <= '0;
      y_q       <= '0;
      ch_q      <= '0;
      if (req_type_i == REQ_GLYPH || req_type_i == REQ_ICON) begin
        status_q <= in_zero ? ST_ZERO : (in_big ? ST_BIG : ST_OK);
      end else begin
        status_q <= ST_OK;
      end
    end
    if (state_q == S_SCAN && tail.active && tail.hit) begin
      status_q <= ST_OK;
      x_q      <= tail.x[11:0];
      y_q      <= tail.y[11:0];
      ch_q     <= tail.ch;
    end
    if (state_q == S_ALLOC) begin
      if (alloc_ok) begin
        status_q <= ST_OK;
        x_q      <= '0;
        y_q      <= wr.base_y[11:0];
        ch_q     <= icon_q ? ICON_CH : {1'b0, min_c};
      end else begin
        status_q <= ST_NOSPACE;
        x_q      <= '0;
        y_q      <= '0;
        ch_q     <= '0;
      end
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE) && !start;
  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign pos_x_o     = x_q;
  assign pos_y_o     = y_q;
  assign channel_o   = ch_q;

  // failed placements carry no position
  `ASA_ASSERT_NOW(a_fail_zero, valid_o && (status_o != ST_OK), (pos_x_o == '0) && (pos_y_o == '0) && (channel_o == '0))
  // an accepted item answers next cycle or keeps the block busy
  `ASA_ASSERT_NEXT(a_answer_or_busy, start && !busy, valid_o || busy)
  // the token reaches the end of the chain only while scanning
  `ASA_ASSERT_NOW(a_tail_scan, tail.active, state_q == S_SCAN)
  // a new row is never written past the table
  `ASA_ASSERT_NOW(a_row_bound, wr.we, used_q < RW'(MAX_ROWS))

endmodule

[sv/asa_cell.sv]
module asa_cell #(
  parameter int IW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [IW-1:0] idx_i,
  input  logic          clear_i,
  input  asa_pkg::req_t req_i,
  input  asa_pkg::wr_t  wr_i,
  input  logic [IW-1:0] wr_idx_i,
  input  asa_pkg::tok_t tok_i,
  output asa_pkg::tok_t tok_o
);
  import asa_pkg::*;

  logic          valid_q, full_q, icon_q;
  logic [AW-1:0] height_q, base_q, fill_q;
  logic [1:0]    ch_q;
  tok_t          tok_q, tok_d;
  logic [AW-1:0] sum;
  logic          match, wr_here;

  assign sum     = fill_q + req_i.w;
  assign match   = tok_i.active && !tok_i.hit && valid_q && !full_q &&
                   (icon_q == req_i.icon) && (height_q == req_i.desired) &&
                   (sum <= req_i.size);
  assign wr_here = wr_i.we && (wr_idx_i == idx_i);

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.hit = 1'b1;
      tok_d.x   = fill_q;
      tok_d.y   = base_q;
      tok_d.ch  = req_i.icon ? ICON_CH : {1'b0, ch_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      full_q  <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (clear_i) begin
        valid_q <= 1'b0;
        full_q  <= 1'b0;
      end else if (wr_here) begin
        valid_q <= 1'b1;
        full_q  <= wr_i.full;
      end else if (match) begin
        full_q <= (sum == req_i.size);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      icon_q   <= wr_i.is_icon;
      height_q <= wr_i.height;
      base_q   <= wr_i.base_y;
      fill_q   <= wr_i.fill;
      ch_q     <= wr_i.ch;
    end else if (match) begin
      fill_q <= sum;
    end
  end

  assign tok_o = tok_q;

endmodule

[dv/asa_checker.sv]
module asa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [12:0] width_i,
  input  logic [12:0] height_i,
  input  logic        valid_o,
  input  logic [1:0]  status_o,
  input  logic [11:0] pos_x_o,
  input  logic [11:0] pos_y_o,
  input  logic [2:0]  channel_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [12:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import asa_pkg::*;

  localparam int NROWS = 64;
  localparam int MAXSZ = 4096;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] x;
    logic [11:0] y;
    logic [2:0]  ch;
  } placement_t;

  placement_t placements_q[$];

  logic [12:0] atlas_cfg;
  bit          rv[NROWS];
  bit          rfull[NROWS];
  bit          ricon[NROWS];
  int unsigned rh[NROWS], rby[NROWS], rfx[NROWS], rch[NROWS];
  int unsigned ctop[4];
  int unsigned floor_y;
  int unsigned nrows;

  function automatic int unsigned atlas_edge();
    int unsigned s;
    s = atlas_cfg;
    if (s < 4) s = 4;
    if (s > MAXSZ) s = MAXSZ;
    return s;
  endfunction

  function automatic void wipe_usage();
    for (int i = 0; i < NROWS; i++) begin
      rv[i] = 0;
      rfull[i] = 0;
    end
    for (int k = 0; k < 4; k++) ctop[k] = 0;
    floor_y = atlas_edge();
    nrows = 0;
  endfunction

  function automatic placement_t place(logic [1:0] kind, int unsigned w, int unsigned h);
    placement_t  r;
    int unsigned size, want, y, c;
    bit          icon;
    r = '0;
    size = atlas_edge();
    icon = (kind == REQ_ICON);
    if (kind == REQ_RESET) begin
      wipe_usage();
      return r;
    end
    if (kind == REQ_UNUSED) return r;
    if (w == 0 || h == 0) begin
      r.status = ST_ZERO;
      return r;
    end
    if (w > size || h > size) begin
      r.status = ST_BIG;
      return r;
    end
    want = (h + 3) & ~32'd3;
    // first fitting open row of the same kind and height
    for (int i = 0; i < NROWS; i++) begin
      if (rv[i] && !rfull[i] && ricon[i] == icon && rh[i] == want && rfx[i] + w <= size) begin
        r.x = rfx[i];
        r.y = rby[i];
        r.ch = icon ? ICON_CH : 3'(rch[i]);
        if (rfx[i] + w == size) rfull[i] = 1;
        rfx[i] = rfx[i] + w;
        return r;
      end
    end
    r.status = ST_NOSPACE;
    if (nrows >= NROWS) return r;
    if (!icon) begin
      c = 0;
      for (int k = 1; k < 4; k++) if (ctop[k] < ctop[c]) c = k;
      if (ctop[c] + want > floor_y) return r;
      y = ctop[c];
      ctop[c] = y + want;
    end else begin
      if (want > floor_y) return r;
      y = floor_y - want;
      for (int k = 0; k < 4; k++) if (y < ctop[k]) return r;
      floor_y = y;
      c = 0;
    end
    rv[nrows] = 1;
    rfull[nrows] = (w == size);
    ricon[nrows] = icon;
    rh[nrows] = want;
    rby[nrows] = y;
    rfx[nrows] = w;
    rch[nrows] = c;
    nrows++;
    r.status = ST_OK;
    r.x = 0;
    r.y = y;
    r.ch = icon ? ICON_CH : 3'(c);
    return r;
  endfunction

  assign pending_o = placements_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    placement_t e;
    if (!rst_ni) begin
      atlas_cfg = 13'd1024;
      wipe_usage();
      placements_q.delete();
      fail_cnt_o <= 0;
    end else begin
      if (valid_o) begin
        if (placements_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          e = placements_q.pop_front();
          if (status_o !== e.status || pos_x_o !== e.x || pos_y_o !== e.y
              || channel_o !== e.ch) begin
            if (status_o !== e.status)
              $error("status exp %0d got %0d", e.status, status_o);
            if (pos_x_o !== e.x) $error("pos_x exp %0d got %0d", e.x, pos_x_o);
            if (pos_y_o !== e.y) $error("pos_y exp %0d got %0d", e.y, pos_y_o);
            if (channel_o !== e.ch)
              $error("channel exp %0d got %0d", e.ch, channel_o);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (start && !busy)
        placements_q = {placements_q, place(req_type_i, width_i, height_i)};
      if (cfg_valid_i && cfg_ready_o) begin
        atlas_cfg = cfg_data_i;
        wipe_usage();
      end
    end
  end
endmodule

[dv/tb_atlas_shelf_allocator.sv]
module tb_atlas_shelf_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import asa_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  req_type_i = '0;
  logic [12:0] width_i = '0;
  logic [12:0] height_i = '0;
  logic        valid_o;
  logic [1:0]  status_o;
  logic [11:0] pos_x_o, pos_y_o;
  logic [2:0]  channel_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [12:0] cfg_data_i = '0;
  int          fail_cnt, pending;
  int          quiet_cycles = 0;
  int          gap_pct;
  int unsigned edge_now;

  int          gap_pct_list[5] = '{0, 81, 12, 0, 81};
  logic [12:0] size_list[5] = '{13'd64, 13'd1024, 13'd0, 13'd256, 13'd5000};

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  atlas_shelf_allocator dut (.*);

  asa_checker u_chk (.*, .fail_cnt_o(fail_cnt), .pending_o(pending));

  // watchdog: any cycle without an accepted beat counts toward the limit
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // one request beat, with a random idle gap before it; start stays high
  // between back-to-back requests
  task automatic send_req(logic [1:0] kind, logic [12:0] w, logic [12:0] h);
    if ($urandom_range(99) < gap_pct) begin
      start <= 0;
      @(posedge clk_i);
      while ($urandom_range(99) < gap_pct) @(posedge clk_i);
    end
    start <= 1;
    req_type_i <= kind;
    width_i <= w;
    height_i <= h;
    do @(posedge clk_i); while (busy);
  endtask

  // config written only when idle: drain, then let the last placement settle
  task automatic write_edge(logic [12:0] v);
    start <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    edge_now = (v < 4) ? 4 : ((v > 4096) ? 4096 : v);
  endtask

  // mostly glyph/icon placements at sizes that build up real shelves
  task automatic random_req();
    int unsigned r, w, h, cap;
    logic [1:0]  kind;
    r = $urandom_range(99);
    cap = (edge_now > 64) ? edge_now / 4 : edge_now;
    kind = (r < 60) ? REQ_GLYPH : (r < 90) ? REQ_ICON : (r < 93) ? REQ_RESET : REQ_UNUSED;
    w = $urandom_range(cap, 1);
    h = 4 * $urandom_range(4, 1) - $urandom_range(3);
    if ($urandom_range(99) < 8) begin
      w = $urandom_range(8191);
      h = $urandom_range(8191);
    end else if ($urandom_range(99) < 5) begin
      w = 0;
    end else if ($urandom_range(99) < 5) begin
      w = edge_now;
    end
    send_req(kind, w[12:0], h[12:0]);
  endtask

  initial begin
    gap_pct = 0;
    edge_now = 1024;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: status paths, extremes, channel rotation, icon stacking
    send_req(REQ_GLYPH, 13'd0, 13'd5);
    send_req(REQ_ICON, 13'd5, 13'd0);
    send_req(REQ_GLYPH, 13'd1025, 13'd4);
    send_req(REQ_ICON, 13'd4, 13'd8191);
    send_req(REQ_UNUSED, 13'h1fff, 13'h1fff);
    for (int k = 0; k < 5; k++) send_req(REQ_GLYPH, 13'd100, 13'd16);
    send_req(REQ_GLYPH, 13'd924, 13'd13);
    send_req(REQ_ICON, 13'd1024, 13'd32);
    send_req(REQ_ICON, 13'd500, 13'd1021);
    send_req(REQ_GLYPH, 13'd1024, 13'd1024);
    send_req(REQ_RESET, 13'd0, 13'd0);
    send_req(REQ_ICON, 13'd1024, 13'd1024);
    send_req(REQ_GLYPH, 13'd1, 13'd1);
    // row table exhaustion with tiny full-width rows
    write_edge(13'd4);
    send_req(REQ_GLYPH, 13'd4, 13'd4);
    send_req(REQ_GLYPH, 13'd4, 13'd1);
    write_edge(13'd4096);
    for (int k = 0; k < 66; k++) send_req(REQ_GLYPH, 13'd4096, 13'd1);
    send_req(REQ_GLYPH, 13'd4096, 13'd4096);
    write_edge(13'h1fff);
    send_req(REQ_ICON, 13'd4096, 13'd4096);

    // random phases across several atlas sizes
    foreach (gap_pct_list[p]) begin
      gap_pct = gap_pct_list[p];
      write_edge(size_list[p]);
      for (int n = 0; n < 170; n++) random_req();
    end

    start <= 0;
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
